### rtl/core/pti_pkg.sv
// Shared types and constants for the prefix tree insert and search block.
`timescale 1ns / 1ps

package pti_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned LETTER_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_PREFIX = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WALK  = 3'd2,
    ST_MARK  = 3'd3,
    ST_REPLY = 3'd4
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLEAR = 2'd3
  } tbl_op_e;

endpackage

### rtl/core/prefix_tree_insert_search.sv
// Top level of the 26-ary prefix tree: letter requests in, one result per finished word.
// A letter request that walks the tree does the child table read, then the update.
// A final letter adds the mark memory access and then the result strobe; a final letter that
// does not walk skips the table read and update. The receiver cannot stall.
// After reset busy stays high while the child table (NODE_COUNT * ALPHABET_SIZE entries)
// and the word-end marks are cleared one entry per cycle.
`timescale 1ns / 1ps

module prefix_tree_insert_search #(
  parameter int unsigned NODE_COUNT    = 256,
  parameter int unsigned ALPHABET_SIZE = 26
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [pti_pkg::CMD_W-1:0]       command_i,
  input  logic [pti_pkg::LETTER_W-1:0]    letter_i,
  input  logic                            last_i,
  input  logic                            empty_word_i,
  output logic                            result_valid_o,
  output logic                            found_o,
  output logic                            status_o
);

  localparam int unsigned NW = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned AW = $clog2(NODE_COUNT * ALPHABET_SIZE);

  pti_pkg::tbl_op_e tbl_op;
  logic [NW-1:0]    tbl_node;
  logic [NW-1:0]    tbl_wdata;
  logic [NW-1:0]    tbl_rdata;
  logic [AW-1:0]    tbl_clr_addr;

  pti_ctrl #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .NW           (NW),
    .AW           (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .letter_i       (letter_i),
    .last_i         (last_i),
    .empty_word_i   (empty_word_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .status_o       (status_o),
    .tbl_op_o       (tbl_op),
    .tbl_node_o     (tbl_node),
    .tbl_wdata_o    (tbl_wdata),
    .tbl_clr_addr_o (tbl_clr_addr),
    .tbl_rdata_i    (tbl_rdata)
  );

  pti_child_table #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .NW           (NW),
    .AW           (AW)
  ) u_child_table (
    .clk_i      (clk_i),
    .op_i       (tbl_op),
    .node_i     (tbl_node),
    .letter_i   (letter_i),
    .wdata_i    (tbl_wdata),
    .clr_addr_i (tbl_clr_addr),
    .rdata_o    (tbl_rdata)
  );

  // An allocation always writes back to the slot read in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_op == pti_pkg::OP_WRITE |-> $past(tbl_op) == pti_pkg::OP_READ)
    else $error("child table written without a preceding read");

  // A result is a single-cycle strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // A full pool is only reported for an insert, which never reports found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> !found_o)
    else $error("found and pool full reported together");

  // No request is taken while a result is being presented.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result presented while idle");

endmodule

### rtl/core/pti_child_table.sv
// Child pointer table: one synchronous memory entry per node and letter.
`timescale 1ns / 1ps

module pti_child_table #(
  parameter int unsigned NODE_COUNT    = 256,
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned NW            = 8,
  parameter int unsigned AW            = 13
) (
  input  logic                             clk_i,
  input  pti_pkg::tbl_op_e                 op_i,
  input  logic [NW-1:0]                    node_i,
  input  logic [pti_pkg::LETTER_W-1:0]     letter_i,
  input  logic [NW-1:0]                    wdata_i,
  input  logic [AW-1:0]                    clr_addr_i,
  output logic [NW-1:0]                    rdata_o
);

  localparam int unsigned Depth = NODE_COUNT * ALPHABET_SIZE;

  logic [NW-1:0] mem [Depth];
  logic [NW-1:0] rdata_q;
  logic [AW-1:0] slot;
  logic [AW-1:0] slot_q;
  logic [AW-1:0] waddr;
  logic [NW-1:0] wdata;
  logic          we;

  // The controller issues no read for a letter outside the alphabet, so it never selects a slot here.
  assign slot = AW'(AW'(node_i) * AW'(ALPHABET_SIZE)) + AW'(letter_i);

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = wdata_i;
    case (op_i)
      pti_pkg::OP_WRITE: begin
        we = 1'b1;
      end
      pti_pkg::OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr_i;
        wdata = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The slot of a read is kept so that an allocation writes back to it.
  always_ff @(posedge clk_i) begin
    if (op_i == pti_pkg::OP_READ) begin
      rdata_q <= mem[slot];
      slot_q  <= slot;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pti_ctrl.sv
// Walk sequencer: cursor, per-word flags, node allocation and word-end marks.
`timescale 1ns / 1ps

module pti_ctrl #(
  parameter int unsigned NODE_COUNT    = 256,
  parameter int unsigned ALPHABET_SIZE = 26,
  parameter int unsigned NW            = 8,
  parameter int unsigned AW            = 13
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [pti_pkg::CMD_W-1:0]       command_i,
  input  logic [pti_pkg::LETTER_W-1:0]    letter_i,
  input  logic                            last_i,
  input  logic                            empty_word_i,
  output logic                            result_valid_o,
  output logic                            found_o,
  output logic                            status_o,
  output pti_pkg::tbl_op_e                tbl_op_o,
  output logic [NW-1:0]                   tbl_node_o,
  output logic [NW-1:0]                   tbl_wdata_o,
  output logic [AW-1:0]                   tbl_clr_addr_o,
  input  logic [NW-1:0]                   tbl_rdata_i
);

  localparam int unsigned Depth = NODE_COUNT * ALPHABET_SIZE;

  pti_pkg::state_e state_q, state_d;
  pti_pkg::cmd_e   cmd_q, cmd_d, cmd_in;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [NW-1:0]   cursor_q, cursor_d;
  logic [NW:0]     used_q, used_d;
  logic            lost_q, lost_d;
  logic            full_q, full_d;
  logic            last_q, last_d;
  logic            accept;
  logic            walk_ok;
  logic            letter_bad;
  logic            path_ok;

  logic            mark_mem [NODE_COUNT];
  logic            mark_q;
  logic            mark_we;
  logic            mark_re;
  logic [NW-1:0]   mark_addr;
  logic            mark_wdata;

  assign accept     = start && (state_q == pti_pkg::ST_IDLE);
  assign letter_bad = 32'(letter_i) >= ALPHABET_SIZE;
  assign walk_ok    = !empty_word_i && !lost_q && !full_q;
  assign path_ok    = !lost_q && !full_q;

  always_comb begin
    case (pti_pkg::cmd_e'(command_i))
      pti_pkg::CMD_INSERT: cmd_in = pti_pkg::CMD_INSERT;
      pti_pkg::CMD_SEARCH: cmd_in = pti_pkg::CMD_SEARCH;
      default:             cmd_in = pti_pkg::CMD_PREFIX;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pti_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(Depth - 1)) begin
          state_d = pti_pkg::ST_IDLE;
        end
      end
      pti_pkg::ST_IDLE: begin
        if (accept) begin
          if (walk_ok && !letter_bad) begin
            state_d = pti_pkg::ST_WALK;
          end else if (last_i) begin
            state_d = pti_pkg::ST_MARK;
          end
        end
      end
      pti_pkg::ST_WALK: begin
        state_d = last_q ? pti_pkg::ST_MARK : pti_pkg::ST_IDLE;
      end
      pti_pkg::ST_MARK: begin
        state_d = pti_pkg::ST_REPLY;
      end
      pti_pkg::ST_REPLY: begin
        state_d = pti_pkg::ST_IDLE;
      end
      default: begin
        state_d = pti_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_cnt_d      = clr_cnt_q;
    cursor_d       = cursor_q;
    used_d         = used_q;
    lost_d         = lost_q;
    full_d         = full_q;
    cmd_d          = cmd_q;
    last_d         = last_q;
    tbl_op_o       = pti_pkg::OP_NONE;
    tbl_wdata_o    = used_q[NW-1:0];
    mark_we        = 1'b0;
    mark_re        = 1'b0;
    mark_addr      = cursor_q;
    mark_wdata     = 1'b1;
    result_valid_o = 1'b0;
    found_o        = 1'b0;
    status_o       = 1'b0;
    case (state_q)
      pti_pkg::ST_CLEAR: begin
        tbl_op_o   = pti_pkg::OP_CLEAR;
        clr_cnt_d  = clr_cnt_q + 1'b1;
        mark_we    = 32'(clr_cnt_q) < NODE_COUNT;
        mark_addr  = clr_cnt_q[NW-1:0];
        mark_wdata = 1'b0;
      end
      pti_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_in;
          last_d = last_i;
          if (walk_ok) begin
            if (letter_bad) begin
              lost_d = 1'b1;
            end else begin
              tbl_op_o = pti_pkg::OP_READ;
            end
          end
        end
      end
      pti_pkg::ST_WALK: begin
        if (tbl_rdata_i != '0) begin
          cursor_d = tbl_rdata_i;
        end else if (cmd_q != pti_pkg::CMD_INSERT) begin
          lost_d = 1'b1;
        end else if (used_q >= (NW+1)'(NODE_COUNT)) begin
          full_d = 1'b1;
        end else begin
          tbl_op_o = pti_pkg::OP_WRITE;
          cursor_d = used_q[NW-1:0];
          used_d   = used_q + 1'b1;
        end
      end
      pti_pkg::ST_MARK: begin
        if (cmd_q == pti_pkg::CMD_INSERT) begin
          mark_we = path_ok;
        end else begin
          mark_re = 1'b1;
        end
      end
      pti_pkg::ST_REPLY: begin
        result_valid_o = 1'b1;
        case (cmd_q)
          pti_pkg::CMD_INSERT: status_o = full_q;
          pti_pkg::CMD_SEARCH: found_o  = path_ok && mark_q;
          default:             found_o  = path_ok;
        endcase
        cursor_d = '0;
        lost_d   = 1'b0;
        full_d   = 1'b0;
      end
      default: begin
        tbl_op_o = pti_pkg::OP_NONE;
      end
    endcase
  end

  assign busy           = state_q != pti_pkg::ST_IDLE;
  assign tbl_node_o     = cursor_q;
  assign tbl_clr_addr_o = clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pti_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
      cursor_q  <= '0;
      used_q    <= (NW+1)'(1);
      lost_q    <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cursor_q  <= cursor_d;
      used_q    <= used_d;
      lost_q    <= lost_d;
      full_q    <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    last_q <= last_d;
  end

  // Word-end marks, one bit per node.
  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_re) begin
      mark_q <= mark_mem[mark_addr];
    end
  end

endmodule
